/* rtl/cleb_pkg.sv */
// Shared constants, types and ring-index helpers for the console line edit buffer.
// No dependencies; imported by the top level, the port checker and the bench.
`timescale 1ns / 1ps

package cleb_pkg;

  // Ring geometry. Indices count modulo twice the depth so full and empty differ.
  localparam int BUF_DEPTH = 128;
  localparam int IDX_SPAN  = 2 * BUF_DEPTH;
  localparam int IDX_W     = $clog2(IDX_SPAN);
  localparam int SLOT_W    = $clog2(BUF_DEPTH);

  // Keystroke codes
  localparam logic [7:0] KEY_NUL    = 8'h00;
  localparam logic [7:0] KEY_CTRL_P = 8'h10;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;
  localparam logic [7:0] KEY_DEL    = 8'h7F;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_CR     = 8'h0D;
  localparam logic [7:0] KEY_LF     = 8'h0A;

  // Item kinds carried on in_tuser
  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SLOT_W-1:0] slot_t;

  // One result word
  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       line_ready;
    logic       dump_request;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       read_empty;
    logic       read_eof;
    logic       read_end;
  } res_t;

  function automatic idx_t idx_inc(idx_t x);
    return (x == IDX_W'(IDX_SPAN - 1)) ? '0 : idx_t'(x + 1'b1);
  endfunction

  function automatic idx_t idx_dec(idx_t x);
    return (x == '0) ? IDX_W'(IDX_SPAN - 1) : idx_t'(x - 1'b1);
  endfunction

  // (a - b) modulo the index span
  function automatic idx_t idx_diff(idx_t a, idx_t b);
    logic [IDX_W:0] t;
    t = {1'b0, a} + (IDX_W + 1)'(IDX_SPAN) - {1'b0, b};
    if (t >= (IDX_W + 1)'(IDX_SPAN)) begin
      t = t - (IDX_W + 1)'(IDX_SPAN);
    end
    return t[IDX_W-1:0];
  endfunction

  // Storage slot of an index
  function automatic slot_t idx_slot(idx_t x);
    idx_t t;
    t = (x >= IDX_W'(BUF_DEPTH)) ? idx_t'(x - IDX_W'(BUF_DEPTH)) : x;
    return t[SLOT_W-1:0];
  endfunction

  // Low byte of an index value, zero-extended when the index is narrower
  function automatic logic [7:0] idx_to_byte(idx_t x);
    logic [IDX_W+7:0] w;
    w = {8'h00, x};
    return w[7:0];
  endfunction

endpackage

/* rtl/cleb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cleb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/console_line_edit_buffer.sv */
// Console line edit buffer: keystroke editing and committed-byte reads on a byte ring.
// Depends on cleb_pkg and cleb_ram.
//
//  channel | direction | tdata                                | tuser      | tlast
//  in_     | sink      | char_in[7:0] first_of_read[8]         | mode[0]    | -
//  out_    | source    | echo/erase/line/dump/read fields      | -          | read_end
//
// One word in, one word out. A word is held in the input register, then its result is
// loaded into the output register; unless the output stalls, a new word can enter every
// cycle. The ring byte at the read index is prefetched from the buffer RAM every cycle,
// with a bypass for a write to the same slot, so unstalled reads run at one per cycle.
// Reset (rst_n low, synchronous) empties the ring; no clearing pass is needed.
// A stalled output holds its word and blocks the input register behind it.
`timescale 1ns / 1ps

module console_line_edit_buffer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] char_in, [8] first_of_read, [15:9] zero
  input  logic [0:0]  in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [0] echo_valid, [8:1] echo_char, [16:9] erase_count,
                                  // [17] line_ready, [18] dump_request, [19] read_valid,
                                  // [27:20] read_byte, [28] read_empty, [29] read_eof
  output logic        out_tlast   // read_end
);

  import cleb_pkg::*;

  // Input register
  logic       stg_valid_r;
  logic       stg_mode_r;
  logic [7:0] stg_char_r;
  logic       stg_first_r;

  // Ring indices
  idx_t read_idx_r,   read_idx_nxt;
  idx_t commit_idx_r, commit_idx_nxt;
  idx_t edit_idx_r,   edit_idx_nxt;

  // Output register
  logic out_valid_r;
  res_t out_res_r;
  res_t res;

  // Buffer RAM and read bypass
  logic       ram_we;
  slot_t      ram_waddr;
  logic [7:0] ram_wdata;
  slot_t      ram_raddr;
  logic [7:0] ram_rdata;
  logic       fwd_hit_r;
  logic [7:0] fwd_data_r;
  logic [7:0] head_byte;

  logic advance;
  logic [7:0] key;
  idx_t edit_inc;

  assign advance   = stg_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stg_valid_r || advance;

  // Byte at the current read index
  assign head_byte = fwd_hit_r ? fwd_data_r : ram_rdata;

  // Item processing
  always_comb begin
    res            = '0;
    read_idx_nxt   = read_idx_r;
    commit_idx_nxt = commit_idx_r;
    edit_idx_nxt   = edit_idx_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_slot(edit_idx_r);
    key            = (stg_char_r == KEY_CR) ? KEY_LF : stg_char_r;
    ram_wdata      = key;
    edit_inc       = idx_inc(edit_idx_r);
    if (advance) begin
      if (stg_mode_r == MODE_KEY) begin
        case (stg_char_r)
          KEY_CTRL_P: res.dump_request = 1'b1;
          KEY_CTRL_U: begin
            res.erase_count = idx_to_byte(idx_diff(edit_idx_r, commit_idx_r));
            edit_idx_nxt    = commit_idx_r;
          end
          KEY_CTRL_H, KEY_DEL: begin
            if (edit_idx_r != commit_idx_r) begin
              edit_idx_nxt    = idx_dec(edit_idx_r);
              res.erase_count = 8'd1;
            end
          end
          default: begin
            if (stg_char_r != KEY_NUL &&
                idx_diff(edit_idx_r, read_idx_r) < IDX_W'(BUF_DEPTH)) begin
              ram_we         = 1'b1;
              edit_idx_nxt   = edit_inc;
              res.echo_valid = 1'b1;
              res.echo_char  = key;
              // newline, end of file or a full ring commits the line
              if (key == KEY_LF || key == KEY_CTRL_D ||
                  idx_diff(edit_inc, read_idx_r) == IDX_W'(BUF_DEPTH)) begin
                commit_idx_nxt = edit_inc;
                res.line_ready = 1'b1;
              end
            end
          end
        endcase
      end else begin
        if (read_idx_r == commit_idx_r) begin
          res.read_empty = 1'b1;
        end else if (head_byte == KEY_CTRL_D) begin
          // end of file is consumed only at the start of a read
          if (stg_first_r) begin
            read_idx_nxt = idx_inc(read_idx_r);
          end
          res.read_eof = 1'b1;
          res.read_end = 1'b1;
        end else begin
          read_idx_nxt   = idx_inc(read_idx_r);
          res.read_valid = 1'b1;
          res.read_byte  = head_byte;
          res.read_end   = (head_byte == KEY_LF);
        end
      end
    end
  end

  // Prefetch the slot the read index will point at next cycle
  assign ram_raddr = idx_slot(read_idx_nxt);

  cleb_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Control and index registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      read_idx_r   <= '0;
      commit_idx_r <= '0;
      edit_idx_r   <= '0;
      fwd_hit_r    <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        stg_valid_r <= 1'b1;
      end else if (advance) begin
        stg_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      read_idx_r   <= read_idx_nxt;
      commit_idx_r <= commit_idx_nxt;
      edit_idx_r   <= edit_idx_nxt;
      fwd_hit_r    <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stg_mode_r  <= in_tuser[0];
      stg_char_r  <= in_tdata[7:0];
      stg_first_r <= in_tdata[8];
    end
    if (advance) begin
      out_res_r <= res;
    end
    fwd_data_r <= ram_wdata;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00,
                       out_res_r.read_eof,
                       out_res_r.read_empty,
                       out_res_r.read_byte,
                       out_res_r.read_valid,
                       out_res_r.dump_request,
                       out_res_r.line_ready,
                       out_res_r.erase_count,
                       out_res_r.echo_char,
                       out_res_r.echo_valid};
  assign out_tlast  = out_res_r.read_end;

endmodule

/* rtl/cleb_checker.sv */
// Port-level checker for the console line edit buffer, bound to the top level.
// Depends on cleb_pkg and console_line_edit_buffer.
`timescale 1ns / 1ps

module cleb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  import cleb_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // Nothing comes out in the cycle after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // Each word reports at most one kind of event
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0({out_tdata[0], out_tdata[16:9] != 8'h00, out_tdata[18],
                             out_tdata[19], out_tdata[28], out_tdata[29]}))
    else $error("result mixes event kinds");

  // A commit only comes with a stored keystroke
  a_commit_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |-> out_tdata[0])
    else $error("line commit without a stored byte");

  // A read ends only at a newline or at end of file
  a_read_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      (out_tdata[19] && out_tdata[27:20] == KEY_LF) || out_tdata[29])
    else $error("read ended without newline or end of file");

endmodule

bind console_line_edit_buffer cleb_checker u_cleb_checker (.*);

/* test/tb_top.sv */
// Self-checking bench for console_line_edit_buffer: drives keystroke and read words,
// predicts every result word from its own copy of the ring and compares field by field.
// Depends on cleb_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
  import cleb_pkg::*;

  localparam int TOTAL_ITEMS  = 1550;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int PRINT_CAP    = 40;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] char_in, [8] first_of_read, [15:9] zero
  logic [0:0]  in_tuser;   // [0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [31:0] out_tdata;  // [0] echo_valid, [8:1] echo_char, [16:9] erase_count,
                           // [17] line_ready, [18] dump_request, [19] read_valid,
                           // [27:20] read_byte, [28] read_empty, [29] read_eof
  logic        out_tlast;  // read_end

  console_line_edit_buffer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Shadow ring: indices run modulo 2*BUF_DEPTH, which is the natural wrap of idx_t
  logic [7:0] line_mem [BUF_DEPTH];
  idx_t       rd_ix = '0;
  idx_t       cm_ix = '0;
  idx_t       ed_ix = '0;

  res_t due_words [$];
  int   n_sent     = 0;
  int   n_mismatch = 0;

  // Idling controls; a long hold starts when hold_req toggles
  logic tx_random   = 1'b0;
  logic rx_random   = 1'b0;
  logic hold_req    = 1'b0;
  logic hold_ack    = 1'b0;
  int   hold_left   = 0;
  int   rx_gap      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(15, 60);
    return $urandom_range(1, 3);
  endfunction

  // One step of the line discipline on the shadow ring
  function automatic res_t edit_step(logic md, logic [7:0] ch, logic fst);
    res_t       r;
    idx_t       fill;
    logic [7:0] c;
    r = '0;
    if (md == MODE_KEY) begin
      c    = ch;
      fill = idx_t'(ed_ix - rd_ix);
      if (c == KEY_CTRL_P) begin
        r.dump_request = 1'b1;
      end else if (c == KEY_CTRL_U) begin
        r.erase_count = 8'(idx_t'(ed_ix - cm_ix));
        ed_ix = cm_ix;
      end else if (c == KEY_CTRL_H || c == KEY_DEL) begin
        if (ed_ix != cm_ix) begin
          ed_ix = idx_t'(ed_ix - 1'b1);
          r.erase_count = 8'd1;
        end
      end else if (c != KEY_NUL && fill < BUF_DEPTH) begin
        if (c == KEY_CR) c = KEY_LF;
        line_mem[ed_ix[SLOT_W-1:0]] = c;
        ed_ix = idx_t'(ed_ix + 1'b1);
        r.echo_valid = 1'b1;
        r.echo_char  = c;
        fill = idx_t'(ed_ix - rd_ix);
        // newline, end of file or a full ring commits the line
        if (c == KEY_LF || c == KEY_CTRL_D || fill == BUF_DEPTH) begin
          cm_ix = ed_ix;
          r.line_ready = 1'b1;
        end
      end
    end else begin
      if (rd_ix == cm_ix) begin
        r.read_empty = 1'b1;
      end else begin
        c = line_mem[rd_ix[SLOT_W-1:0]];
        if (c == KEY_CTRL_D) begin
          // only the first byte of a read consumes the end-of-file mark
          if (fst) rd_ix = idx_t'(rd_ix + 1'b1);
          r.read_eof = 1'b1;
          r.read_end = 1'b1;
        end else begin
          rd_ix = idx_t'(rd_ix + 1'b1);
          r.read_valid = 1'b1;
          r.read_byte  = c;
          r.read_end   = (c == KEY_LF);
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_mismatch++;
    if (n_mismatch <= PRINT_CAP) begin
      $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    end
  endtask

  // Offer one word, wait for acceptance, record its prediction, then maybe idle
  task automatic send_word(input logic md, input logic [7:0] ch, input logic fst,
                           output res_t r);
    int gap;
    in_tdata  <= {7'd0, fst, ch};
    in_tuser  <= md;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    r = edit_step(md, ch, fst);
    due_words.push_back(r);
    n_sent++;
    gap = (tx_random && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Keystroke; first_of_read is a don't-care here
  task automatic type_key(input logic [7:0] ch);
    res_t r;
    send_word(MODE_KEY, ch, 1'($urandom), r);
  endtask

  // Read; char_in is a don't-care here
  task automatic take_read(input logic fst, output res_t r);
    send_word(MODE_READ, 8'($urandom), fst, r);
  endtask

  // Act as a reader: take bytes until the read ends or nothing is committed
  task automatic read_line();
    res_t r;
    logic fst;
    int   guard;
    fst   = 1'b1;
    guard = 0;
    do begin
      take_read(fst, r);
      fst = 1'b0;
      guard++;
    end while (!r.read_end && !r.read_empty && guard < 2 * BUF_DEPTH);
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // A line of random content with some editing, ended by LF, CR or Control-D
  task automatic type_line();
    int len;
    int p;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 120) : $urandom_range(0, 15);
    for (int i = 0; i < len; i++) begin
      p = $urandom_range(0, 99);
      if (p < 5)       type_key(KEY_CTRL_H);
      else if (p < 8)  type_key(KEY_DEL);
      else if (p < 10) type_key(KEY_CTRL_U);
      else if (p < 14) type_key(8'($urandom_range(8'h80, 8'hFF)));
      else             type_key(printable());
    end
    p = $urandom_range(0, 99);
    if (p < 50)      type_key(KEY_LF);
    else if (p < 85) type_key(KEY_CR);
    else             type_key(KEY_CTRL_D);
  endtask

  // Empty ring: reads report empty, editing keys and NUL do nothing, Control-P dumps
  task automatic test_empty_and_ignored();
    res_t r;
    take_read(1'b1, r);
    take_read(1'b0, r);
    type_key(KEY_NUL);
    type_key(KEY_CTRL_H);
    type_key(KEY_DEL);
    type_key(KEY_CTRL_P);
    type_key(KEY_CTRL_U);
  endtask

  // Editing, CR to LF, commit on newline and Control-D, end-of-file on read
  task automatic test_line_edit();
    res_t r;
    type_key("a");
    type_key("b");
    type_key(KEY_CTRL_H);
    type_key("c");
    type_key(KEY_CTRL_U);
    type_key("h");
    type_key("i");
    type_key(KEY_CR);
    read_line();
    type_key("x");
    type_key(KEY_CTRL_D);
    take_read(1'b1, r);
    take_read(1'b0, r);   // Control-D not first: stays in the ring
    take_read(1'b1, r);   // now consumed
    type_key(KEY_CTRL_D);
    take_read(1'b1, r);
    type_key(8'hFF);
    type_key(8'h80);
    type_key(8'h01);
    type_key(KEY_LF);
    read_line();
    take_read(1'b1, r);
  endtask

  // Fill the ring to force a commit, drop keys while full, drain it, longest erase
  task automatic test_ring_full();
    res_t r;
    tx_random = 1'b1;
    rx_random = 1'b1;
    repeat (BUF_DEPTH + 2) type_key(printable());
    type_key(KEY_CTRL_H);
    type_key(KEY_CTRL_U);
    take_read(1'b1, r);
    repeat (BUF_DEPTH - 1) take_read(1'b0, r);
    take_read(1'b0, r);
    repeat (BUF_DEPTH - 1) type_key(printable());
    type_key(KEY_CTRL_U);
  endtask

  // Receiver holds off for a long stretch while words keep coming
  task automatic test_backpressure();
    res_t r;
    tx_random = 1'b0;
    hold_req <= ~hold_req;
    for (int i = 0; i < 40; i++) begin
      if (i % 5 == 4) type_key(KEY_LF);
      else if (i % 3 == 0) take_read(1'($urandom), r);
      else type_key(printable());
    end
    read_line();
  endtask

  // Mostly well-formed typing and reading sessions, the rest raw noise
  task automatic test_random_sessions();
    res_t r;
    int   nlines;
    while (n_sent < TOTAL_ITEMS) begin
      tx_random = ($urandom_range(0, 3) != 0);
      rx_random = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) begin
        nlines = $urandom_range(1, 3);
        repeat (nlines) type_line();
        // now and then leave lines unread so the ring backs up
        if ($urandom_range(0, 5) != 0) repeat (nlines) read_line();
      end else begin
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(0, 1) == 0) type_key(8'($urandom_range(0, 255)));
          else take_read(1'($urandom), r);
        end
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold when asked
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap     <= rx_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (rx_random && $urandom_range(0, 3) == 0) rx_gap <= pick_gap();
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.echo_valid   = out_tdata[0];
      got.echo_char    = out_tdata[8:1];
      got.erase_count  = out_tdata[16:9];
      got.line_ready   = out_tdata[17];
      got.dump_request = out_tdata[18];
      got.read_valid   = out_tdata[19];
      got.read_byte    = out_tdata[27:20];
      got.read_empty   = out_tdata[28];
      got.read_eof     = out_tdata[29];
      got.read_end     = out_tlast;
      if (due_words.size() == 0) begin
        report_mismatch("result word with none due", out_tdata, 0);
      end else begin
        want = due_words.pop_front();
        if (got.echo_valid !== want.echo_valid)
          report_mismatch("echo_valid", got.echo_valid, want.echo_valid);
        if (got.echo_char !== want.echo_char)
          report_mismatch("echo_char", got.echo_char, want.echo_char);
        if (got.erase_count !== want.erase_count)
          report_mismatch("erase_count", got.erase_count, want.erase_count);
        if (got.line_ready !== want.line_ready)
          report_mismatch("line_ready", got.line_ready, want.line_ready);
        if (got.dump_request !== want.dump_request)
          report_mismatch("dump_request", got.dump_request, want.dump_request);
        if (got.read_valid !== want.read_valid)
          report_mismatch("read_valid", got.read_valid, want.read_valid);
        if (got.read_byte !== want.read_byte)
          report_mismatch("read_byte", got.read_byte, want.read_byte);
        if (got.read_empty !== want.read_empty)
          report_mismatch("read_empty", got.read_empty, want.read_empty);
        if (got.read_eof !== want.read_eof)
          report_mismatch("read_eof", got.read_eof, want.read_eof);
        if (got.read_end !== want.read_end)
          report_mismatch("read_end", got.read_end, want.read_end);
      end
    end
  end

  // Watchdog: too many cycles in a row with no word moving on either side
  initial begin : stall_watch
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_ignored();
    test_line_edit();
    test_ring_full();
    test_backpressure();
    test_random_sessions();

    in_tvalid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/cleb_pkg.sv
rtl/cleb_ram.sv
rtl/console_line_edit_buffer.sv
rtl/cleb_checker.sv
test/tb_top.sv
